@@ rtl/core/stun_br_pkg.sv @@
// shared types, constants and helper functions for the stun binding responder
// used by stun_br_crc and stun_binding_responder; no dependencies
package stun_br_pkg;

  localparam int unsigned COUNT_W     = 17;
  localparam int unsigned REPLY_IDX_W = 5;
  localparam int unsigned TXN_DEPTH   = 12;
  localparam int unsigned TXN_IDX_W   = 4;

  localparam logic [COUNT_W-1:0]     COUNT_MAX  = '1;
  localparam logic [COUNT_W-1:0]     HDR_LEN    = COUNT_W'(20);
  localparam logic [COUNT_W-1:0]     TXN_FIRST  = COUNT_W'(8);
  localparam logic [REPLY_IDX_W-1:0] REPLY_LAST = REPLY_IDX_W'(27);
  localparam logic [REPLY_IDX_W-1:0] REPLY_TXN  = REPLY_IDX_W'(8);
  localparam logic [REPLY_IDX_W-1:0] REPLY_ATTR = REPLY_IDX_W'(20);

  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;
  localparam logic [31:0] FP_XOR       = 32'h5354554E;

  localparam logic [15:0] MSG_TYPE_REQUEST = 16'h0001;
  localparam logic [15:0] MSG_TYPE_SUCCESS = 16'h0101;

  // fingerprint attribute header: type 0x8028, length 4
  localparam logic [7:0] ATTR_TYPE_HI = 8'h80;
  localparam logic [7:0] ATTR_TYPE_LO = 8'h28;
  localparam logic [7:0] ATTR_LEN_HI  = 8'h00;
  localparam logic [7:0] ATTR_LEN_LO  = 8'h04;

  typedef logic [1:0] verdict_t;
  localparam verdict_t VERDICT_PASS    = 2'd0;
  localparam verdict_t VERDICT_SUCCESS = 2'd1;
  localparam verdict_t VERDICT_REQUEST = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CRC,
    ST_VERDICT,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] seed;
    logic [7:0]  data;
  } crc_req_t;

  // first eight reply bytes: success type, length 8, magic cookie
  function automatic logic [7:0] prefix_byte(input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = 8'h01;
      3'd1:    b = 8'h01;
      3'd2:    b = 8'h00;
      3'd3:    b = 8'h08;
      3'd4:    b = 8'h21;
      3'd5:    b = 8'h12;
      3'd6:    b = 8'hA4;
      default: b = 8'h42;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] cookie_byte(input logic [1:0] i);
    logic [7:0] b;
    case (i)
      2'd0:    b = 8'h21;
      2'd1:    b = 8'h12;
      2'd2:    b = 8'hA4;
      default: b = 8'h42;
    endcase
    return b;
  endfunction

  // crc register after the fixed reply prefix, worked out at elaboration
  function automatic logic [31:0] crc_prefix();
    logic [31:0] c;
    c = CRC_ALL_ONES;
    for (int i = 0; i < 8; i++) begin
      c = c ^ {24'b0, prefix_byte(3'(i))};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return c;
  endfunction

  localparam logic [31:0] CRC_PREFIX = crc_prefix();

endpackage

@@ rtl/core/stun_br_crc.sv @@
// bit-serial reflected crc-32 unit, one bit per cycle, each byte folded in bit by bit
// depends on stun_br_pkg
module stun_br_crc (
  input  logic                  clk,
  input  logic                  rst_n,
  input  stun_br_pkg::crc_req_t req,
  output logic                  done,
  output logic [31:0]           crc
);

  logic        busy_r;
  logic [2:0]  cnt_r;
  logic [31:0] sh_r;
  logic [31:0] sh_step;

  assign sh_step = sh_r[0] ? ((sh_r >> 1) ^ stun_br_pkg::CRC_POLY) : (sh_r >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= 3'd0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sh_r <= req.seed ^ {24'b0, req.data};
    end else if (busy_r) begin
      sh_r <= sh_step;
    end
  end

  // high during the final shift, so the value is ready on the next cycle
  assign done = busy_r && (cnt_r == 3'd7);
  assign crc  = sh_r;

endmodule

@@ rtl/core/stun_binding_responder.sv @@
// stun binding responder: parses a datagram byte stream, gives a verdict and
// answers a binding request with a 28-byte success reply; uses stun_br_pkg, stun_br_crc
//
//   channel  | ports                                         | direction
//   in       | in_valid in_stall in_data_byte in_last_byte   | datagram bytes in
//   out      | out_valid out_stall out_verdict               | results out
//            | out_first_request out_reply_valid             |
//            | out_reply_byte out_last_of_run                |
//
// each byte is accepted in the idle state; transaction id bytes (8 to 19) then hold
// in_stall high while the crc unit folds them in one bit per cycle
// the final byte is followed by a verdict and, for a request, the 28 reply bytes
// output register stalls hold the sequencer and in turn in_stall
// reset (rst_n low, synchronous) clears the parser and the request-seen flag
module stun_binding_responder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_verdict,
  output logic       out_first_request,
  output logic       out_reply_valid,
  output logic [7:0] out_reply_byte,
  output logic       out_last_of_run
);

  stun_br_pkg::state_t state_r, state_nxt;

  logic [stun_br_pkg::COUNT_W-1:0]     byte_count_r;
  logic [15:0]                         message_type_r;
  logic [15:0]                         message_length_r;
  logic                                cookie_match_r;
  logic [7:0]                          txn_r [stun_br_pkg::TXN_DEPTH];
  logic                                request_seen_r;
  logic                                last_r;
  logic                                first_r;
  logic [stun_br_pkg::REPLY_IDX_W-1:0] reply_idx_r, reply_idx_nxt;

  logic                                out_valid_r;
  stun_br_pkg::verdict_t               out_verdict_r;
  logic                                out_first_request_r;
  logic                                out_reply_valid_r;
  logic [7:0]                          out_reply_byte_r;
  logic                                out_last_of_run_r;

  stun_br_pkg::crc_req_t crc_req;
  logic                  crc_start;
  logic                  crc_done;
  logic [31:0]           crc_val;

  logic                               in_accept;
  logic                               load_ok;
  logic                               is_txn;
  logic [stun_br_pkg::TXN_IDX_W-1:0]  txn_wr_idx;
  logic [stun_br_pkg::TXN_IDX_W-1:0]  txn_rd_idx;
  logic [stun_br_pkg::COUNT_W-1:0]    need_len;
  stun_br_pkg::verdict_t              verdict;
  logic [31:0]                        fp;
  logic [7:0]                         reply_byte;
  logic                               verdict_load;
  logic                               reply_load;
  logic                               clear_dgram;

  stun_br_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (crc_req),
    .done  (crc_done),
    .crc   (crc_val)
  );

  assign in_accept  = in_valid && !in_stall;
  assign load_ok    = !out_valid_r || !out_stall;
  assign is_txn     = (byte_count_r >= stun_br_pkg::TXN_FIRST) &&
                      (byte_count_r < stun_br_pkg::HDR_LEN);
  assign txn_wr_idx = byte_count_r[stun_br_pkg::TXN_IDX_W-1:0] -
                      stun_br_pkg::TXN_IDX_W'(8);
  assign txn_rd_idx = stun_br_pkg::TXN_IDX_W'(reply_idx_r - stun_br_pkg::REPLY_TXN);

  // acceptance: full header, cookie, the whole message body present, and a success or request type
  assign need_len = stun_br_pkg::HDR_LEN + {1'b0, message_length_r};
  always_comb begin
    verdict = stun_br_pkg::VERDICT_PASS;
    if (byte_count_r >= stun_br_pkg::HDR_LEN && cookie_match_r &&
        byte_count_r >= need_len) begin
      if (message_type_r == stun_br_pkg::MSG_TYPE_SUCCESS) begin
        verdict = stun_br_pkg::VERDICT_SUCCESS;
      end else if (message_type_r == stun_br_pkg::MSG_TYPE_REQUEST) begin
        verdict = stun_br_pkg::VERDICT_REQUEST;
      end
    end
  end

  assign fp = ~crc_val ^ stun_br_pkg::FP_XOR;

  always_comb begin
    if (reply_idx_r < stun_br_pkg::REPLY_TXN) begin
      reply_byte = stun_br_pkg::prefix_byte(reply_idx_r[2:0]);
    end else if (reply_idx_r < stun_br_pkg::REPLY_ATTR) begin
      reply_byte = txn_r[txn_rd_idx];
    end else begin
      case (reply_idx_r[2:0])
        3'd4:    reply_byte = stun_br_pkg::ATTR_TYPE_HI;
        3'd5:    reply_byte = stun_br_pkg::ATTR_TYPE_LO;
        3'd6:    reply_byte = stun_br_pkg::ATTR_LEN_HI;
        3'd7:    reply_byte = stun_br_pkg::ATTR_LEN_LO;
        3'd0:    reply_byte = fp[31:24];
        3'd1:    reply_byte = fp[23:16];
        3'd2:    reply_byte = fp[15:8];
        default: reply_byte = fp[7:0];
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stun_br_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (is_txn) begin
            state_nxt = stun_br_pkg::ST_CRC;
          end else if (in_last_byte) begin
            state_nxt = stun_br_pkg::ST_VERDICT;
          end
        end
      end
      stun_br_pkg::ST_CRC: begin
        if (crc_done) begin
          state_nxt = last_r ? stun_br_pkg::ST_VERDICT : stun_br_pkg::ST_IDLE;
        end
      end
      stun_br_pkg::ST_VERDICT: begin
        if (load_ok) begin
          state_nxt = (verdict == stun_br_pkg::VERDICT_REQUEST) ?
                      stun_br_pkg::ST_REPLY : stun_br_pkg::ST_IDLE;
        end
      end
      stun_br_pkg::ST_REPLY: begin
        if (load_ok && reply_idx_r == stun_br_pkg::REPLY_LAST) begin
          state_nxt = stun_br_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stun_br_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall      = 1'b1;
    crc_start     = 1'b0;
    verdict_load  = 1'b0;
    reply_load    = 1'b0;
    reply_idx_nxt = reply_idx_r;
    case (state_r)
      stun_br_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        crc_start = in_accept && is_txn;
      end
      stun_br_pkg::ST_CRC: begin
        in_stall = 1'b1;
      end
      stun_br_pkg::ST_VERDICT: begin
        verdict_load  = load_ok;
        reply_idx_nxt = '0;
      end
      stun_br_pkg::ST_REPLY: begin
        reply_load = load_ok;
        if (load_ok) begin
          reply_idx_nxt = reply_idx_r + stun_br_pkg::REPLY_IDX_W'(1);
        end
      end
      default: in_stall = 1'b1;
    endcase
  end

  // first transaction byte restarts from the precomputed prefix crc
  assign crc_req = '{start: crc_start,
                     seed:  (byte_count_r == stun_br_pkg::TXN_FIRST) ?
                            stun_br_pkg::CRC_PREFIX : crc_val,
                     data:  in_data_byte};

  assign clear_dgram = (verdict_load && verdict != stun_br_pkg::VERDICT_REQUEST) ||
                       (reply_load && reply_idx_r == stun_br_pkg::REPLY_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= stun_br_pkg::ST_IDLE;
      byte_count_r     <= '0;
      message_type_r   <= '0;
      message_length_r <= '0;
      cookie_match_r   <= 1'b0;
      request_seen_r   <= 1'b0;
      last_r           <= 1'b0;
      first_r          <= 1'b0;
      reply_idx_r      <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      reply_idx_r <= reply_idx_nxt;
      if (in_accept) begin
        last_r <= in_last_byte;
        case (byte_count_r)
          stun_br_pkg::COUNT_W'(0): message_type_r[15:8]   <= in_data_byte;
          stun_br_pkg::COUNT_W'(1): message_type_r[7:0]    <= in_data_byte;
          stun_br_pkg::COUNT_W'(2): message_length_r[15:8] <= in_data_byte;
          stun_br_pkg::COUNT_W'(3): message_length_r[7:0]  <= in_data_byte;
          stun_br_pkg::COUNT_W'(4): begin
            cookie_match_r <= (in_data_byte == stun_br_pkg::cookie_byte(2'd0));
          end
          stun_br_pkg::COUNT_W'(5), stun_br_pkg::COUNT_W'(6),
          stun_br_pkg::COUNT_W'(7): begin
            cookie_match_r <= cookie_match_r &&
              (in_data_byte == stun_br_pkg::cookie_byte(byte_count_r[1:0]));
          end
          default: cookie_match_r <= cookie_match_r;
        endcase
        if (byte_count_r != stun_br_pkg::COUNT_MAX) begin
          byte_count_r <= byte_count_r + stun_br_pkg::COUNT_W'(1);
        end
      end
      if (verdict_load && verdict == stun_br_pkg::VERDICT_REQUEST) begin
        request_seen_r <= 1'b1;
        first_r        <= !request_seen_r;
      end
      if (clear_dgram) begin
        byte_count_r     <= '0;
        message_type_r   <= '0;
        message_length_r <= '0;
        cookie_match_r   <= 1'b0;
      end
      if (verdict_load || reply_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && is_txn) begin
      txn_r[txn_wr_idx] <= in_data_byte;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (verdict_load) begin
      out_verdict_r       <= verdict;
      out_first_request_r <= (verdict == stun_br_pkg::VERDICT_REQUEST) && !request_seen_r;
      out_reply_valid_r   <= 1'b0;
      out_reply_byte_r    <= 8'h00;
      out_last_of_run_r   <= (verdict != stun_br_pkg::VERDICT_REQUEST);
    end else if (reply_load) begin
      out_verdict_r       <= stun_br_pkg::VERDICT_REQUEST;
      out_first_request_r <= first_r;
      out_reply_valid_r   <= 1'b1;
      out_reply_byte_r    <= reply_byte;
      out_last_of_run_r   <= (reply_idx_r == stun_br_pkg::REPLY_LAST);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_verdict       = out_verdict_r;
  assign out_first_request = out_first_request_r;
  assign out_reply_valid   = out_reply_valid_r;
  assign out_reply_byte    = out_reply_byte_r;
  assign out_last_of_run   = out_last_of_run_r;

endmodule
